>>> hdl/lrs_pkg.sv
// Shared types and constants for the block range to slice splitter.
package lrs_pkg;

    localparam int BLOCKS_PER_SLICE = 4;
    localparam int SLICE_SHIFT      = $clog2(BLOCKS_PER_SLICE);
    localparam int MAX_BLOCKS       = 252;

    localparam int CMD_W    = 2;
    localparam int TAG_W    = 8;
    localparam int LBA_W    = 32;
    localparam int LEN_W    = 8;
    localparam int SLICE_W  = 30;
    localparam int DMA_W    = 8;
    localparam int OFFSET_W = 2;
    localparam int BCOUNT_W = 3;
    localparam int NSLICE_W = 7;
    localparam int SUM_W    = LEN_W + 1;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } lrs_state_t;

    // One classified command as it waits between the front and the back.
    typedef struct packed
    {
        logic                err;
        logic                is_write;
        logic [TAG_W-1:0]    tag;
        logic [SLICE_W-1:0]  slice_addr;
        logic [OFFSET_W-1:0] offset;
        logic [BCOUNT_W-1:0] first_count;
        logic [BCOUNT_W-1:0] tail_count;
        logic [NSLICE_W-1:0] num_slices;
    } lrs_desc_t;

    typedef struct packed
    {
        logic empty;
        logic full;
    } lrs_qstat_t;

endpackage

>>> hdl/lrs_front.sv
// Front end: accepts a command word and classifies it into a slice descriptor.
module lrs_front
    import lrs_pkg::*;
(
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [TAG_W-1:0]    tag,
    input  logic [LBA_W-1:0]    start_lba,
    input  logic [LEN_W-1:0]    count_minus_one,
    input  lrs_qstat_t          qstat,
    output logic                push,
    output lrs_desc_t           push_desc
);

    logic [SUM_W-1:0]    nblocks;
    logic [SUM_W-1:0]    span;
    logic [OFFSET_W-1:0] offset;
    logic [NSLICE_W-1:0] full_bounds;
    logic [BCOUNT_W-1:0] tail;
    logic                supported;
    logic                too_long;
    logic                has_tail;

    assign cmd_stall = qstat.full;
    assign push      = cmd_valid && !qstat.full;

    always_comb
    begin
        nblocks     = {1'b0, count_minus_one} + SUM_W'(1);
        too_long    = nblocks > SUM_W'(MAX_BLOCKS);
        supported   = command inside {CMD_READ, CMD_WRITE};
        offset      = start_lba[SLICE_SHIFT-1:0];
        span        = SUM_W'(offset) + nblocks;
        // Number of slice boundaries crossed, and blocks left past the last one.
        full_bounds = NSLICE_W'(span >> SLICE_SHIFT);
        tail        = BCOUNT_W'(span[SLICE_SHIFT-1:0]);
        has_tail    = (tail != '0) && (full_bounds != '0);

        push_desc          = '0;
        push_desc.tag      = tag;
        if (!supported || too_long)
        begin
            push_desc.err        = 1'b1;
            push_desc.num_slices = NSLICE_W'(1);
        end
        else
        begin
            push_desc.is_write    = (command == CMD_WRITE);
            push_desc.slice_addr  = start_lba[LBA_W-1:SLICE_SHIFT];
            push_desc.offset      = offset;
            push_desc.first_count = (full_bounds != '0)
                                    ? BCOUNT_W'(BLOCKS_PER_SLICE) - BCOUNT_W'(offset)
                                    : nblocks[BCOUNT_W-1:0];
            push_desc.tail_count  = tail;
            // A range that never reaches a boundary still needs its one slice.
            push_desc.num_slices  = (full_bounds == '0)
                                    ? NSLICE_W'(1)
                                    : full_bounds + NSLICE_W'(has_tail);
        end
    end

endmodule

>>> hdl/lrs_queue.sv
// Short descriptor queue that decouples the front end from the slice sequencer.
module lrs_queue
    import lrs_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lrs_desc_t  push_desc,
    input  logic       pop,
    output lrs_desc_t  pop_desc,
    output lrs_qstat_t qstat
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    lrs_desc_t         entry_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + ADDR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + ADDR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign pop_desc    = entry_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH) || pop))
        else $error("descriptor queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("descriptor queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("descriptor queue count beyond depth");
`endif

endmodule

>>> hdl/lrs_back.sv
// Back end: walks one descriptor; one slice request word per cycle when not stalled.
module lrs_back
    import lrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lrs_qstat_t          qstat,
    input  lrs_desc_t           pop_desc,
    output logic                pop,
    output logic                req_valid,
    input  logic                req_stall,
    output logic                is_write,
    output logic [TAG_W-1:0]    out_tag,
    output logic [SLICE_W-1:0]  slice_addr,
    output logic [DMA_W-1:0]    dma_index,
    output logic [OFFSET_W-1:0] block_offset,
    output logic [BCOUNT_W-1:0] block_count,
    output logic                last,
    output logic                error
);

    lrs_state_t          state_reg;
    lrs_state_t          state_next;
    lrs_desc_t           work_reg;
    logic [NSLICE_W-1:0] remain_reg;
    logic [NSLICE_W-1:0] remain_next;
    logic                first_reg;
    logic                first_next;
    logic [SLICE_W-1:0]  sa_reg;
    logic [SLICE_W-1:0]  sa_next;
    logic [DMA_W-1:0]    idx_reg;
    logic [DMA_W-1:0]    idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                emit;
    logic                res_last;
    logic [BCOUNT_W-1:0] res_count;
    logic [OFFSET_W-1:0] res_offset;

    logic                out_write_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [SLICE_W-1:0]  out_sa_reg;
    logic [DMA_W-1:0]    out_dma_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [BCOUNT_W-1:0] out_count_reg;
    logic                out_last_reg;
    logic                out_err_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit && res_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = (state_reg == ST_IDLE) && !qstat.empty;
        emit = (state_reg == ST_RUN) && (!out_valid_reg || !req_stall);

        res_last = (remain_reg == NSLICE_W'(1));
        // Only the first slice can start inside a slice; only the last can end early.
        if (first_reg)
        begin
            res_count  = work_reg.first_count;
            res_offset = work_reg.offset;
        end
        else
        begin
            res_count  = (res_last && work_reg.tail_count != '0)
                         ? work_reg.tail_count : BCOUNT_W'(BLOCKS_PER_SLICE);
            res_offset = '0;
        end

        remain_next = remain_reg;
        first_next  = first_reg;
        sa_next     = sa_reg;
        idx_next    = idx_reg;
        if (pop)
        begin
            remain_next = pop_desc.num_slices;
            first_next  = 1'b1;
            sa_next     = pop_desc.slice_addr;
            idx_next    = '0;
        end
        else if (emit)
        begin
            remain_next = remain_reg - NSLICE_W'(1);
            first_next  = 1'b0;
            sa_next     = sa_reg + SLICE_W'(1);
            idx_next    = idx_reg + DMA_W'(res_count);
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && req_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg  <= sa_next;
        idx_reg <= idx_next;
        if (pop)
        begin
            work_reg <= pop_desc;
        end
        if (emit)
        begin
            out_write_reg  <= work_reg.is_write;
            out_tag_reg    <= work_reg.tag;
            out_sa_reg     <= sa_reg;
            out_dma_reg    <= idx_reg;
            out_offset_reg <= res_offset;
            out_count_reg  <= res_count;
            out_last_reg   <= res_last;
            out_err_reg    <= work_reg.err;
        end
    end

    assign req_valid    = out_valid_reg;
    assign is_write     = out_write_reg;
    assign out_tag      = out_tag_reg;
    assign slice_addr   = out_sa_reg;
    assign dma_index    = out_dma_reg;
    assign block_offset = out_offset_reg;
    assign block_count  = out_count_reg;
    assign last         = out_last_reg;
    assign error        = out_err_reg;

`ifndef SYNTH
    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> remain_reg != '0)
        else $error("sequencer running with no slices left");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_last_reg && out_count_reg == '0))
        else $error("rejected command word not a single empty word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg <= BCOUNT_W'(BLOCKS_PER_SLICE))
        else $error("slice block count beyond slice size");
`endif

endmodule

>>> hdl/lba_range_to_slice_splitter.sv
// Top level of the block range to slice splitter.
//
//   channel   valid      stall      payload
//   command   cmd_valid  cmd_stall  command, tag, start_lba, count_minus_one
//   request   req_valid  req_stall  is_write, out_tag, slice_addr, dma_index,
//                                   block_offset, block_count, last, error
//
// A command that yields S slice requests occupies the sequencer: it first loads its
// descriptor from the queue, then emits one request word per cycle unless stalled.
// The front end classifies in the accept cycle; up to QUEUE_DEPTH commands wait
// in the descriptor queue, and cmd_stall is high only while that queue is full.
// Reset is asynchronous and needs no clearing pass; req_stall holds the output word.
module lba_range_to_slice_splitter
    import lrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [TAG_W-1:0]    tag,
    input  logic [LBA_W-1:0]    start_lba,
    input  logic [LEN_W-1:0]    count_minus_one,
    output logic                req_valid,
    input  logic                req_stall,
    output logic                is_write,
    output logic [TAG_W-1:0]    out_tag,
    output logic [SLICE_W-1:0]  slice_addr,
    output logic [DMA_W-1:0]    dma_index,
    output logic [OFFSET_W-1:0] block_offset,
    output logic [BCOUNT_W-1:0] block_count,
    output logic                last,
    output logic                error
);

    lrs_qstat_t qstat;
    lrs_desc_t  push_desc;
    lrs_desc_t  pop_desc;
    logic       push;
    logic       pop;

    lrs_front u_front
    (
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command         (command),
        .tag             (tag),
        .start_lba       (start_lba),
        .count_minus_one (count_minus_one),
        .qstat           (qstat),
        .push            (push),
        .push_desc       (push_desc)
    );

    lrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .qstat     (qstat)
    );

    lrs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .pop_desc     (pop_desc),
        .pop          (pop),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .is_write     (is_write),
        .out_tag      (out_tag),
        .slice_addr   (slice_addr),
        .dma_index    (dma_index),
        .block_offset (block_offset),
        .block_count  (block_count),
        .last         (last),
        .error        (error)
    );

endmodule

>>> dv/tb_lba_range_to_slice_splitter.sv
`timescale 1ns / 100ps
// Self-checking testbench for the block range to slice splitter.
module tb_lba_range_to_slice_splitter;
    import lrs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 2'd3;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed
    {
        logic [CMD_W-1:0] command;
        logic [TAG_W-1:0] tag;
        logic [LBA_W-1:0] start_lba;
        logic [LEN_W-1:0] count_minus_one;
    } host_cmd_t;

    typedef struct packed
    {
        logic                is_write;
        logic [TAG_W-1:0]    tag;
        logic [SLICE_W-1:0]  slice_addr;
        logic [DMA_W-1:0]    dma_index;
        logic [OFFSET_W-1:0] block_offset;
        logic [BCOUNT_W-1:0] block_count;
        logic                last;
        logic                error;
    } slice_req_t;

    // Works out the slice requests of each accepted command and matches them
    // against the request words that leave the block.
    class slice_request_book;
        slice_req_t    due_requests[$];
        int            mismatches;
        logic [SLICE_W-1:0] next_slice;
        logic [DMA_W-1:0]   blocks_covered;

        function new();
            due_requests.delete();
            mismatches     = 0;
            next_slice     = '0;
            blocks_covered = '0;
        endfunction

        function void plan_slices(host_cmd_t c);
            slice_req_t       r;
            logic [8:0]       nblocks;
            logic [8:0]       span;
            logic [8:0]       tail;
            logic [SLICE_W-1:0] sa;
            logic [DMA_W-1:0] idx;
            int               whole;
            nblocks = {1'b0, c.count_minus_one} + 9'd1;
            r = '0;
            r.tag = c.tag;
            if ((c.command != CMD_READ && c.command != CMD_WRITE) || nblocks > MAX_BLOCKS)
            begin
                r.last  = 1'b1;
                r.error = 1'b1;
                due_requests.push_back(r);
                return;
            end
            r.is_write     = (c.command == CMD_WRITE);
            r.block_offset = OFFSET_W'(c.start_lba % BLOCKS_PER_SLICE);
            sa    = SLICE_W'(c.start_lba / BLOCKS_PER_SLICE);
            span  = nblocks + 9'(r.block_offset);
            whole = span / BLOCKS_PER_SLICE;
            tail  = 9'(span % BLOCKS_PER_SLICE);
            // The head slice covers the whole range when it never reaches a boundary.
            r.slice_addr  = sa;
            r.block_count = (whole != 0) ? BCOUNT_W'(BLOCKS_PER_SLICE - r.block_offset)
                                         : BCOUNT_W'(nblocks);
            due_requests.push_back(r);
            idx = DMA_W'(r.block_count);
            sa  = sa + 1'b1;
            r.block_offset = '0;
            r.block_count  = BCOUNT_W'(BLOCKS_PER_SLICE);
            for (int s = 1; s < whole; s++)
            begin
                r.slice_addr = sa;
                r.dma_index  = idx;
                due_requests.push_back(r);
                idx = idx + DMA_W'(BLOCKS_PER_SLICE);
                sa  = sa + 1'b1;
            end
            if (tail != 0 && whole != 0)
            begin
                r.slice_addr  = sa;
                r.dma_index   = idx;
                r.block_count = BCOUNT_W'(tail);
                due_requests.push_back(r);
                idx = idx + DMA_W'(tail);
                sa  = sa + 1'b1;
            end
            due_requests[due_requests.size() - 1].last = 1'b1;
            next_slice     = sa;
            blocks_covered = idx;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_request(slice_req_t got);
            slice_req_t want;
            if (due_requests.size() == 0)
            begin
                $display("%0t: unexpected request word, expected none, got %0h", $time, got);
                mismatches++;
                return;
            end
            want = due_requests.pop_front();
            compare_field("is_write", want.is_write, got.is_write);
            compare_field("out_tag", want.tag, got.tag);
            compare_field("slice_addr", want.slice_addr, got.slice_addr);
            compare_field("dma_index", want.dma_index, got.dma_index);
            compare_field("block_offset", want.block_offset, got.block_offset);
            compare_field("block_count", want.block_count, got.block_count);
            compare_field("last", want.last, got.last);
            compare_field("error", want.error, got.error);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [CMD_W-1:0]    command = '0;
    logic [TAG_W-1:0]    tag = '0;
    logic [LBA_W-1:0]    start_lba = '0;
    logic [LEN_W-1:0]    count_minus_one = '0;
    logic                req_valid;
    logic                req_stall = 1'b0;
    logic                is_write;
    logic [TAG_W-1:0]    out_tag;
    logic [SLICE_W-1:0]  slice_addr;
    logic [DMA_W-1:0]    dma_index;
    logic [OFFSET_W-1:0] block_offset;
    logic [BCOUNT_W-1:0] block_count;
    logic                last;
    logic                error;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 1'b0;
    int  cycle_count = 0;
    slice_request_book book = new();

    lba_range_to_slice_splitter dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command         (command),
        .tag             (tag),
        .start_lba       (start_lba),
        .count_minus_one (count_minus_one),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .is_write        (is_write),
        .out_tag         (out_tag),
        .slice_addr      (slice_addr),
        .dma_index       (dma_index),
        .block_offset    (block_offset),
        .block_count     (block_count),
        .last            (last),
        .error           (error)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_lba_range_to_slice_splitter: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        req_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            book.match_request({is_write, out_tag, slice_addr, dma_index, block_offset,
                                block_count, last, error});
    end

    // Stalls the request side for a long stretch so the descriptor queue fills.
    task automatic hold_requests(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off = 1'b0;
    endtask

    task automatic issue_command(host_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_valid       <= 1'b0;
            command         <= CMD_W'($urandom);
            tag             <= TAG_W'($urandom);
            start_lba       <= $urandom;
            count_minus_one <= LEN_W'($urandom);
        end
        @(negedge clk);
        cmd_valid       <= 1'b1;
        command         <= c.command;
        tag             <= c.tag;
        start_lba       <= c.start_lba;
        count_minus_one <= c.count_minus_one;
        do
            @(posedge clk);
        while (cmd_stall);
        book.plan_slices(c);
    endtask

    function automatic host_cmd_t random_command();
        host_cmd_t c;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 5)
            c.command = CMD_RSVD_LO;
        else if (pick < 10)
            c.command = CMD_RSVD_HI;
        else
            c.command = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        c.tag = TAG_W'($urandom_range(255));
        // Mostly short transfers keep the run quick; a few reach the full length.
        pick = $urandom_range(99);
        if (pick < 55)
            c.count_minus_one = LEN_W'($urandom_range(15));
        else if (pick < 85)
            c.count_minus_one = LEN_W'($urandom_range(MAX_BLOCKS - 1));
        else if (pick < 92)
            c.count_minus_one = LEN_W'(MAX_BLOCKS - 1);
        else
            c.count_minus_one = LEN_W'($urandom_range(255, MAX_BLOCKS));
        if ($urandom_range(9) == 0)
            c.start_lba = 32'hFFFF_FFFF - $urandom_range(15);
        else
            c.start_lba = $urandom;
        return c;
    endfunction

    initial
    begin
        host_cmd_t directed[$];
        directed = '{
            '{CMD_READ,    8'h00, 32'h0000_0000, 8'd0},
            '{CMD_WRITE,   8'hFF, 32'h0000_0003, 8'd0},
            '{CMD_READ,    8'h11, 32'h0000_0001, 8'd1},
            '{CMD_READ,    8'h22, 32'h0000_0000, 8'd3},
            '{CMD_WRITE,   8'h33, 32'h0000_0002, 8'd5},
            '{CMD_READ,    8'h44, 32'h0000_0001, 8'd9},
            '{CMD_WRITE,   8'h55, 32'h0000_0000, 8'd251},
            '{CMD_READ,    8'h66, 32'h0000_0003, 8'd251},
            '{CMD_WRITE,   8'h77, 32'hFFFF_FFFF, 8'd7},
            '{CMD_WRITE,   8'h88, 32'hFFFF_FFFC, 8'd251},
            '{CMD_READ,    8'h99, 32'hAAAA_5555, 8'd252},
            '{CMD_WRITE,   8'hAA, 32'h5555_AAAA, 8'd255},
            '{CMD_RSVD_LO, 8'hBB, 32'h1234_5678, 8'd4},
            '{CMD_RSVD_HI, 8'hCC, 32'hFFFF_FFFF, 8'd255},
            '{CMD_READ,    8'hA5, 32'hFFFF_FFFE, 8'd0},
            '{CMD_WRITE,   8'h5A, 32'h8000_0001, 8'd2}
        };
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            issue_command(directed[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 13 : 0;
            if (phase == 2)
            begin
                fork
                    hold_requests(HOLD_CYCLES);
                join_none
            end
            repeat (ITEMS_PER_PHASE)
                issue_command(random_command());
        end
        @(negedge clk);
        cmd_valid <= 1'b0;

        while (book.due_requests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.mismatches == 0)
            $display("tb_lba_range_to_slice_splitter: clean");
        else
            $display("tb_lba_range_to_slice_splitter: errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/lrs_pkg.sv
hdl/lrs_front.sv
hdl/lrs_queue.sv
hdl/lrs_back.sv
hdl/lba_range_to_slice_splitter.sv
dv/tb_lba_range_to_slice_splitter.sv
